// ===== rtl/tcfm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfm_pkg
// Shared types, constants and helper functions of the time code frame
// modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfm_pkg;

   // Frame geometry and special seconds.
   localparam int unsigned FRAME_BITS  = 60;
   localparam logic [5:0]  LAST_SECOND = 6'd59;

   // Frame bit positions.
   localparam int unsigned POS_SUMMER   = 17;
   localparam int unsigned POS_WINTER   = 18;
   localparam int unsigned POS_START    = 20;
   localparam int unsigned POS_MIN_LO   = 21;
   localparam int unsigned POS_MIN_PAR  = 28;
   localparam int unsigned POS_HOUR_LO  = 29;
   localparam int unsigned POS_HOUR_PAR = 35;
   localparam int unsigned POS_DAY_LO   = 36;
   localparam int unsigned POS_WDAY_LO  = 42;
   localparam int unsigned POS_MON_LO   = 45;
   localparam int unsigned POS_YEAR_LO  = 50;
   localparam int unsigned POS_DATE_PAR = 58;

   // Weekday coding: Sunday comes in as zero and goes out as seven.
   localparam logic [2:0] WDAY_SUNDAY_IN  = 3'd0;
   localparam logic [2:0] WDAY_SUNDAY_OUT = 3'd7;

   // Register select, taken from paddr[2].
   localparam logic REG_ZERO_DIP = 1'b0;
   localparam logic REG_ONE_DIP  = 1'b1;

   localparam logic [9:0] ZERO_DIP_RESET = 10'd100;
   localparam logic [9:0] ONE_DIP_RESET  = 10'd200;

   typedef struct packed {
      logic [5:0]  second;
      logic [9:0]  millisecond;
      logic [15:0] minute_tag;
      logic [5:0]  next_minute;
      logic [4:0]  next_hour;
      logic [4:0]  day_of_month;
      logic [2:0]  weekday;
      logic [3:0]  month;
      logic [6:0]  year_two_digit;
      logic        summer_time;
   } tcfm_item_type;

   typedef struct packed {
      logic [9:0] zero_dip_ms;
      logic [9:0] one_dip_ms;
   } tcfm_cfg_type;

   // Binary to packed BCD for values up to 99. The tens digit comes from a
   // multiplication by 205/2048, which is exact for all values up to 127.
   function automatic logic [7:0] to_bcd(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(value) * 15'd205;
      tens = prod[14:11];
      ones = value - (7'(tens) * 7'd10);
      return {tens, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tcfm_req_if.sv =====
// ----------------------------------------------------------------------------
// tcfm_req_if
// Input channel of the time code frame modulator: one clock sample a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcfm_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second;
   logic [9:0]  millisecond;
   logic [15:0] minute_tag;
   logic [5:0]  next_minute;
   logic [4:0]  next_hour;
   logic [4:0]  day_of_month;
   logic [2:0]  weekday;
   logic [3:0]  month;
   logic [6:0]  year_two_digit;
   logic        summer_time;

   modport source (
      output valid, second, millisecond, minute_tag, next_minute, next_hour,
             day_of_month, weekday, month, year_two_digit, summer_time,
      input  ready
   );

   modport sink (
      input  valid, second, millisecond, minute_tag, next_minute, next_hour,
             day_of_month, weekday, month, year_two_digit, summer_time,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/tcfm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcfm_rsp_if
// Result channel of the time code frame modulator: carrier state and frame bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcfm_rsp_if;
   logic valid;
   logic ready;
   logic carrier_on;
   logic current_bit;

   modport source (
      output valid, carrier_on, current_bit,
      input  ready
   );

   modport sink (
      input  valid, carrier_on, current_bit,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/tcfm_csr.sv =====
// ----------------------------------------------------------------------------
// tcfm_csr
// APB-style register file holding the two dip lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfm_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output tcfm_pkg::tcfm_cfg_type     cfg
);
   import tcfm_pkg::*;

   logic [9:0] zero_dip_ff, zero_dip_in;
   logic [9:0] one_dip_ff,  one_dip_in;
   logic       write_en;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite & pready;

   always_comb begin
      zero_dip_in = zero_dip_ff;
      one_dip_in  = one_dip_ff;
      if (write_en) begin
         unique case (paddr[2])
            REG_ZERO_DIP: zero_dip_in = pwdata[9:0];
            REG_ONE_DIP:  one_dip_in  = pwdata[9:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_dip_ff <= ZERO_DIP_RESET;
         one_dip_ff  <= ONE_DIP_RESET;
      end else begin
         zero_dip_ff <= zero_dip_in;
         one_dip_ff  <= one_dip_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ZERO_DIP: prdata = {22'd0, zero_dip_ff};
         REG_ONE_DIP:  prdata = {22'd0, one_dip_ff};
         default:      prdata = 32'd0;
      endcase
   end

   assign cfg.zero_dip_ms = zero_dip_ff;
   assign cfg.one_dip_ms  = one_dip_ff;

endmodule

`default_nettype wire

// ===== rtl/tcfm_encoder.sv =====
// ----------------------------------------------------------------------------
// tcfm_encoder
// Builds the 60-bit time code frame from the announced time fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfm_encoder (
   input  wire tcfm_pkg::tcfm_item_type item,
   output logic [tcfm_pkg::FRAME_BITS-1:0] frame
);
   import tcfm_pkg::*;

   logic [7:0] min_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] day_bcd;
   logic [7:0] mon_bcd;
   logic [7:0] year_bcd;
   logic [2:0] wday_code;

   assign min_bcd   = to_bcd({1'b0, item.next_minute});
   assign hour_bcd  = to_bcd({2'b0, item.next_hour});
   assign day_bcd   = to_bcd({2'b0, item.day_of_month});
   assign mon_bcd   = to_bcd({3'b0, item.month});
   assign year_bcd  = to_bcd(item.year_two_digit);
   assign wday_code = (item.weekday == WDAY_SUNDAY_IN) ? WDAY_SUNDAY_OUT : item.weekday;

   always_comb begin
      frame = '0;
      frame[POS_SUMMER] = item.summer_time;
      frame[POS_WINTER] = ~item.summer_time;
      frame[POS_START]  = 1'b1;
      frame[POS_MIN_LO  +: 7] = min_bcd[6:0];
      frame[POS_MIN_PAR]      = ^min_bcd[6:0];
      frame[POS_HOUR_LO +: 6] = hour_bcd[5:0];
      frame[POS_HOUR_PAR]     = ^hour_bcd[5:0];
      frame[POS_DAY_LO  +: 6] = day_bcd[5:0];
      frame[POS_WDAY_LO +: 3] = wday_code;
      frame[POS_MON_LO  +: 5] = mon_bcd[4:0];
      frame[POS_YEAR_LO +: 8] = year_bcd;
      frame[POS_DATE_PAR]     = ^{day_bcd[5:0], wday_code, mon_bcd[4:0], year_bcd};
   end

endmodule

`default_nettype wire

// ===== rtl/tcfm_engine.sv =====
// ----------------------------------------------------------------------------
// tcfm_engine
// Input register, frame and dip state, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfm_engine (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire tcfm_pkg::tcfm_item_type req_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_carrier_on,
   output logic                         rsp_current_bit,
   input  wire tcfm_pkg::tcfm_cfg_type  cfg
);
   import tcfm_pkg::*;

   // Input stage.
   logic          s1_valid_ff, s1_valid_in;
   tcfm_item_type s1_item_ff;

   // Frame and dip state.
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [15:0]           tag_ff, tag_in;
   logic                  frame_valid_ff, frame_valid_in;
   logic [5:0]            prev_sec_ff, prev_sec_in;
   logic                  seen_ff, seen_in;
   logic [9:0]            dip_ff, dip_in;
   logic                  carrier_ff, carrier_in;

   // Result stage.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_carrier_ff, rsp_bit_ff;

   logic                  out_free;
   logic                  advance;
   logic [FRAME_BITS-1:0] built_frame;
   logic [FRAME_BITS-1:0] frame_use;
   logic [5:0]            sec;
   logic                  tag_new;
   logic                  new_second;
   logic [9:0]            dip_mid;
   logic                  carrier_mid;
   logic                  dip_done;

   tcfm_encoder u_encoder (
      .item  (s1_item_ff),
      .frame (built_frame)
   );

   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign advance     = s1_valid_ff & out_free;
   assign req_ready   = ~s1_valid_ff | out_free;
   assign s1_valid_in = (req_valid & req_ready) | (s1_valid_ff & ~out_free);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   assign sec        = (s1_item_ff.second > LAST_SECOND) ? LAST_SECOND : s1_item_ff.second;
   assign tag_new    = ~frame_valid_ff | (s1_item_ff.minute_tag != tag_ff);
   assign new_second = ~seen_ff | (sec != prev_sec_ff) | tag_new;
   assign frame_use  = tag_new ? built_frame : frame_ff;

   always_comb begin
      dip_mid     = dip_ff;
      carrier_mid = carrier_ff;
      if (new_second) begin
         if (sec == LAST_SECOND) begin
            dip_mid     = '0;
            carrier_mid = 1'b1;
         end else begin
            dip_mid     = frame_use[sec] ? cfg.one_dip_ms : cfg.zero_dip_ms;
            carrier_mid = (dip_mid == '0);
         end
      end
   end

   assign dip_done = (dip_mid != '0) && (s1_item_ff.millisecond >= dip_mid);

   always_comb begin
      frame_in       = frame_ff;
      tag_in         = tag_ff;
      frame_valid_in = frame_valid_ff;
      prev_sec_in    = prev_sec_ff;
      seen_in        = seen_ff;
      dip_in         = dip_ff;
      carrier_in     = carrier_ff;
      if (advance) begin
         frame_in       = frame_use;
         tag_in         = s1_item_ff.minute_tag;
         frame_valid_in = 1'b1;
         prev_sec_in    = sec;
         seen_in        = 1'b1;
         dip_in         = dip_done ? '0 : dip_mid;
         carrier_in     = dip_done | carrier_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         frame_valid_ff <= 1'b0;
         seen_ff        <= 1'b0;
         dip_ff         <= '0;
         carrier_ff     <= 1'b1;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_valid_ff <= frame_valid_in;
         seen_ff        <= seen_in;
         dip_ff         <= dip_in;
         carrier_ff     <= carrier_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_carrier_ff <= carrier_in;
         rsp_bit_ff     <= frame_use[sec];
      end
      frame_ff    <= frame_in;
      tag_ff      <= tag_in;
      prev_sec_ff <= prev_sec_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_carrier_on  = rsp_carrier_ff;
   assign rsp_current_bit = rsp_bit_ff;

endmodule

`default_nettype wire

// ===== rtl/time_code_frame_modulator_core.sv =====
// ----------------------------------------------------------------------------
// time_code_frame_modulator_core
// Long-wave time code modulator: turns clock samples into carrier on/off
// decisions that follow a 60-bit minute frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Contents
//   req_bus   in         valid/ready        one sample of the local clock
//   rsp_bus   out        valid/ready        carrier_on, current_bit
//   csr       in/out     APB setup+access   zero_dip_ms (0x0), one_dip_ms (0x4)
//
// A sample is registered on the transfer; once the result register is free, one
// pass of logic decides the frame and the carrier and loads the result register,
// which offers the result. One sample can be taken every cycle while results are
// taken. The result register is the only throttle: while it is full and not
// taken, a sample in the input register holds, and once both registers are full
// req_bus.ready follows rsp_bus.ready. Reset is synchronous and puts the carrier
// on with no frame built; the dip lengths return to 100 ms and 200 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module time_code_frame_modulator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   tcfm_req_if.sink         req_bus,
   tcfm_rsp_if.source       rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import tcfm_pkg::*;

   tcfm_cfg_type  cfg;
   tcfm_item_type req_item;

   // The register file holds the two dip lengths; the engine reads them with
   // no hold. Writes must come only while no sample is in flight; not enforced.
   tcfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Gather the sample fields into one payload word for the input register.
   assign req_item.second         = req_bus.second;
   assign req_item.millisecond    = req_bus.millisecond;
   assign req_item.minute_tag     = req_bus.minute_tag;
   assign req_item.next_minute    = req_bus.next_minute;
   assign req_item.next_hour      = req_bus.next_hour;
   assign req_item.day_of_month   = req_bus.day_of_month;
   assign req_item.weekday        = req_bus.weekday;
   assign req_item.month          = req_bus.month;
   assign req_item.year_two_digit = req_bus.year_two_digit;
   assign req_item.summer_time    = req_bus.summer_time;

   // The engine rebuilds the frame when the minute tag changes or no frame is
   // built, starts a dip at each new second other than the last one, and ends
   // the dip once the millisecond count reaches its length.
   tcfm_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_item        (req_item),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_carrier_on  (rsp_bus.carrier_on),
      .rsp_current_bit (rsp_bus.current_bit),
      .cfg             (cfg)
   );

endmodule

`default_nettype wire

// ===== verif/tcfm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfm_checker
// Watches the sample, result and register ports of the time code frame
// modulator. It keeps its own frame, carrier and dip-length state, predicts
// one carrier level and frame bit per sample transfer, and compares each
// result transfer with the oldest prediction. It also checks register reads.
// ----------------------------------------------------------------------------

module tcfm_checker (
   input  logic        clock,
   input  logic        reset,
   tcfm_req_if         req_bus,
   tcfm_rsp_if         rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int unsigned fail_count,
   output int unsigned pending_count
);
   import tcfm_pkg::*;

   typedef struct packed {
      logic carrier_on;
      logic current_bit;
   } level_type;

   level_type level_queue[$];

   logic [FRAME_BITS-1:0] frame_bits;
   logic [15:0]           built_tag;
   logic                  frame_built;
   logic [5:0]            last_second;
   logic                  second_known;
   logic [9:0]            dip_ms;
   logic                  carrier;
   logic [9:0]            zero_dip;
   logic [9:0]            one_dip;

   tcfm_item_type sample;
   level_type     predicted;
   level_type     oldest;

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [7:0] bcd_digits(input int unsigned value);
      return 8'(((value / 10) << 4) | (value % 10));
   endfunction

   // Over-range fields keep only their own bit count after BCD coding.
   function automatic logic [FRAME_BITS-1:0] compose_frame(input tcfm_item_type s);
      logic [FRAME_BITS-1:0] f;
      logic [6:0]            mi;
      logic [5:0]            hr;
      logic [5:0]            dy;
      logic [2:0]            wd;
      logic [4:0]            mo;
      logic [7:0]            yr;
      mi = 7'(bcd_digits(s.next_minute));
      hr = 6'(bcd_digits(s.next_hour));
      dy = 6'(bcd_digits(s.day_of_month));
      wd = (s.weekday == WDAY_SUNDAY_IN) ? WDAY_SUNDAY_OUT : s.weekday;
      mo = 5'(bcd_digits(s.month));
      yr = bcd_digits(s.year_two_digit);
      f = '0;
      f[POS_SUMMER] = s.summer_time;
      f[POS_WINTER] = ~s.summer_time;
      f[POS_START] = 1'b1;
      f[POS_MIN_LO +: 7] = mi;
      f[POS_MIN_PAR] = ^mi;
      f[POS_HOUR_LO +: 6] = hr;
      f[POS_HOUR_PAR] = ^hr;
      f[POS_DAY_LO +: 6] = dy;
      f[POS_WDAY_LO +: 3] = wd;
      f[POS_MON_LO +: 5] = mo;
      f[POS_YEAR_LO +: 8] = yr;
      f[POS_DATE_PAR] = ^{dy, wd, mo, yr};
      return f;
   endfunction

   task automatic modulate_sample(input tcfm_item_type s, output level_type lv);
      logic [5:0] sec;
      logic       fresh_tag;
      sec = (s.second > LAST_SECOND) ? LAST_SECOND : s.second;
      fresh_tag = !frame_built || (s.minute_tag != built_tag);
      if (!second_known || sec != last_second || fresh_tag) begin
         second_known = 1'b1;
         last_second = sec;
         if (fresh_tag) begin
            frame_bits = compose_frame(s);
            built_tag = s.minute_tag;
            frame_built = 1'b1;
         end
         if (sec == LAST_SECOND) begin
            dip_ms = '0;
            carrier = 1'b1;
         end else begin
            dip_ms = frame_bits[sec] ? one_dip : zero_dip;
            carrier = (dip_ms == '0);
         end
      end
      if (dip_ms != '0 && s.millisecond >= dip_ms) begin
         carrier = 1'b1;
         dip_ms = '0;
      end
      lv.carrier_on = carrier;
      lv.current_bit = frame_bits[sec];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         level_queue.delete();
         frame_bits = '0;
         built_tag = '0;
         frame_built = 1'b0;
         last_second = '0;
         second_known = 1'b0;
         dip_ms = '0;
         carrier = 1'b1;
         zero_dip = ZERO_DIP_RESET;
         one_dip = ONE_DIP_RESET;
         pending_count <= 0;
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_ONE_DIP) one_dip = pwdata[9:0];
               else zero_dip = pwdata[9:0];
            end else if (prdata[9:0] != ((paddr[2] == REG_ONE_DIP) ? one_dip : zero_dip)) begin
               report_mismatch($sformatf("register read at 0x%0h returned %0d",
                                         paddr, prdata[9:0]));
            end
         end

         if (req_bus.valid && req_bus.ready) begin
            sample.second = req_bus.second;
            sample.millisecond = req_bus.millisecond;
            sample.minute_tag = req_bus.minute_tag;
            sample.next_minute = req_bus.next_minute;
            sample.next_hour = req_bus.next_hour;
            sample.day_of_month = req_bus.day_of_month;
            sample.weekday = req_bus.weekday;
            sample.month = req_bus.month;
            sample.year_two_digit = req_bus.year_two_digit;
            sample.summer_time = req_bus.summer_time;
            modulate_sample(sample, predicted);
            level_queue.push_back(predicted);
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            if (level_queue.size() == 0) begin
               report_mismatch("result transfer with no sample outstanding");
            end else begin
               oldest = level_queue.pop_front();
               if (rsp_bus.carrier_on !== oldest.carrier_on)
                  report_mismatch($sformatf("carrier_on expected %0b, got %0b",
                                            oldest.carrier_on, rsp_bus.carrier_on));
               if (rsp_bus.current_bit !== oldest.current_bit)
                  report_mismatch($sformatf("current_bit expected %0b, got %0b",
                                            oldest.current_bit, rsp_bus.current_bit));
            end
         end

         pending_count <= level_queue.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the time code frame modulator. A directed run at
// the reset dip lengths is followed by several register settings, each with
// a stretch of random clock samples that mostly walk through real minutes.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;
   import tcfm_pkg::*;

   // Byte addresses of the two dip-length registers.
   localparam logic [2:0]  ADDR_ZERO_DIP   = 3'h0;
   localparam logic [2:0]  ADDR_ONE_DIP    = 3'h4;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned RANDOM_ITEMS    = 550;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned PRESSURE_AFTER  = 200;
   localparam int unsigned PRESSURE_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tcfm_req_if req_bus ();
   tcfm_rsp_if rsp_bus ();

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned rsp_transfers = 0;

   // When steady_flow is set, neither side inserts idle cycles.
   bit steady_flow = 1'b0;
   bit pressure_done = 1'b0;

   // State of the simulated local clock that the well-formed samples follow.
   logic [5:0]    walk_second;
   logic [9:0]    walk_ms;
   logic [15:0]   walk_tag;
   int unsigned   walk_left;
   tcfm_item_type walk_fields;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   time_code_frame_modulator_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tcfm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Cycle and result-transfer counters. The result count decides when the
   // long receiver hold-off starts.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_bus.valid && rsp_bus.ready) rsp_transfers <= rsp_transfers + 1;
   end

   // The run is cut off if it ever gets this far: a hung handshake or a lost
   // result never lets the main sequence finish.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // Idle lengths are mostly zero or short, with the occasional long gap.
   function automatic int unsigned idle_length();
      int unsigned r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Result-side flow control. Ready is dropped for a random idle length and
   // then raised for a random stretch. Once, after a few hundred results, the
   // receiver holds off for a long count of cycles so that the output
   // register fills and the block pushes back on the sample channel.
   initial begin
      int unsigned hold;
      rsp_bus.ready = 1'b0;
      forever begin
         if (!pressure_done && rsp_transfers >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold = PRESSURE_CYCLES;
         end else begin
            hold = idle_length();
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   function automatic tcfm_item_type make_sample(
      input logic [5:0]  sec,
      input logic [9:0]  ms,
      input logic [15:0] tag,
      input logic [5:0]  mi,
      input logic [4:0]  hr,
      input logic [4:0]  dy,
      input logic [2:0]  wd,
      input logic [3:0]  mo,
      input logic [6:0]  yr,
      input logic        st
   );
      tcfm_item_type s;
      s.second = sec;
      s.millisecond = ms;
      s.minute_tag = tag;
      s.next_minute = mi;
      s.next_hour = hr;
      s.day_of_month = dy;
      s.weekday = wd;
      s.month = mo;
      s.year_two_digit = yr;
      s.summer_time = st;
      return s;
   endfunction

   // A sample with every bit of every field random, out-of-range values
   // included.
   function automatic tcfm_item_type noise_sample();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[62:0];
   endfunction

   // Offer one sample after a random gap and wait for its transfer. Valid is
   // left high afterwards; the next call either replaces the payload or
   // drops valid at the following falling edge.
   task automatic push_sample(input tcfm_item_type s);
      int unsigned gap;
      gap = idle_length();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.second = s.second;
      req_bus.millisecond = s.millisecond;
      req_bus.minute_tag = s.minute_tag;
      req_bus.next_minute = s.next_minute;
      req_bus.next_hour = s.next_hour;
      req_bus.day_of_month = s.day_of_month;
      req_bus.weekday = s.weekday;
      req_bus.month = s.month;
      req_bus.year_two_digit = s.year_two_digit;
      req_bus.summer_time = s.summer_time;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = write;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // Write both dip lengths with junk in the unused upper bits, then read
   // them back so the checker can compare.
   task automatic set_dips(input logic [9:0] zero_ms, input logic [9:0] one_ms);
      csr_access(1'b1, ADDR_ZERO_DIP, {22'($urandom()), zero_ms});
      csr_access(1'b1, ADDR_ONE_DIP, {22'($urandom()), one_ms});
      csr_access(1'b0, ADDR_ZERO_DIP, '0);
      csr_access(1'b0, ADDR_ONE_DIP, '0);
   endtask

   // Stop offering samples and wait until every result has been taken, plus
   // a few cycles to cover the two-stage pipeline.
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   // New in-range broken-down time for the minute that the walk enters.
   task automatic roll_minute();
      walk_fields.next_minute = 6'($urandom_range(0, 59));
      walk_fields.next_hour = 5'($urandom_range(0, 23));
      walk_fields.day_of_month = 5'($urandom_range(1, 31));
      walk_fields.weekday = 3'($urandom_range(0, 6));
      walk_fields.month = 4'($urandom_range(1, 12));
      walk_fields.year_two_digit = 7'($urandom_range(0, 99));
      walk_fields.summer_time = 1'($urandom_range(0, 1));
   endtask

   // Advance the local clock: a few samples per second with rising
   // milliseconds, then the next second, and at the end of the minute a new
   // tag and a new announced time.
   task automatic walk_step();
      int unsigned next_ms;
      if (walk_left == 0) begin
         if (walk_second >= LAST_SECOND) begin
            walk_second = '0;
            walk_tag = walk_tag + 16'd1;
            roll_minute();
         end else begin
            walk_second = walk_second + 6'd1;
         end
         walk_left = $urandom_range(1, 4);
         walk_ms = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(0, 150));
      end else begin
         next_ms = walk_ms + $urandom_range(20, 400);
         walk_ms = (next_ms > 999) ? 10'd999 : 10'(next_ms);
      end
      walk_left--;
   endtask

   function automatic tcfm_item_type walk_sample();
      tcfm_item_type s;
      s = walk_fields;
      s.second = walk_second;
      s.millisecond = walk_ms;
      s.minute_tag = walk_tag;
      return s;
   endfunction

   initial begin
      int unsigned   phase;
      int unsigned   n;
      int unsigned   roll;
      logic [9:0]    zero_ms;
      logic [9:0]    one_ms;

      // Every block input is known from time zero.
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.second = '0;
      req_bus.millisecond = '0;
      req_bus.minute_tag = '0;
      req_bus.next_minute = '0;
      req_bus.next_hour = '0;
      req_bus.day_of_month = '0;
      req_bus.weekday = '0;
      req_bus.month = '0;
      req_bus.year_two_digit = '0;
      req_bus.summer_time = 1'b0;
      walk_second = 6'd40;
      walk_ms = '0;
      walk_tag = 16'd100;
      walk_left = 0;
      walk_fields = '0;
      roll_minute();

      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset dip lengths of 100 ms and 200 ms.
      // The very first sample builds a frame even though its tag equals the
      // reset tag; Sunday is announced here.
      push_sample(make_sample(6'd0, 10'd0, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      // Zero bit: the dip ends exactly at 100 ms.
      push_sample(make_sample(6'd0, 10'd99, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd0, 10'd100, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      // Winter-time flag bits and the always-one start bit with a long dip.
      push_sample(make_sample(6'd17, 10'd0, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd18, 10'd0, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd18, 10'd150, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd20, 10'd0, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd20, 10'd199, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd20, 10'd200, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      // Second 59 has no dip; seconds above 59 count as 59, so they do not
      // start a new second.
      push_sample(make_sample(6'd59, 10'd0, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd60, 10'd500, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      push_sample(make_sample(6'd63, 10'd999, 16'h0000, 6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0));
      // A tag change within the same second rebuilds the frame; every time
      // field at its bit-width maximum, weekday seven and summer time.
      push_sample(make_sample(6'd63, 10'd0, 16'hFFFF, 6'd63, 5'd31, 5'd31, 3'd7, 4'd15, 7'd127,
                              1'b1));
      push_sample(make_sample(6'd21, 10'd0, 16'hFFFF, 6'd63, 5'd31, 5'd31, 3'd7, 4'd15, 7'd127,
                              1'b1));
      push_sample(make_sample(6'd28, 10'd0, 16'hFFFF, 6'd63, 5'd31, 5'd31, 3'd7, 4'd15, 7'd127,
                              1'b1));
      push_sample(make_sample(6'd35, 10'd50, 16'hFFFF, 6'd63, 5'd31, 5'd31, 3'd7, 4'd15, 7'd127,
                              1'b1));
      push_sample(make_sample(6'd58, 10'd0, 16'hFFFF, 6'd63, 5'd31, 5'd31, 3'd7, 4'd15, 7'd127,
                              1'b1));
      // A millisecond count beyond 999 still ends the dip.
      push_sample(make_sample(6'd58, 10'd1023, 16'hFFFF, 6'd63, 5'd31, 5'd31, 3'd7, 4'd15,
                              7'd127, 1'b1));
      // Top of every legal range, rebuilt in the middle of a second.
      push_sample(make_sample(6'd58, 10'd0, 16'h1234, 6'd59, 5'd23, 5'd31, 3'd6, 4'd12, 7'd99,
                              1'b1));
      push_sample(make_sample(6'd17, 10'd0, 16'h1234, 6'd59, 5'd23, 5'd31, 3'd6, 4'd12, 7'd99,
                              1'b1));
      push_sample(make_sample(6'd42, 10'd10, 16'h1234, 6'd59, 5'd23, 5'd31, 3'd6, 4'd12, 7'd99,
                              1'b1));
      push_sample(make_sample(6'd50, 10'd300, 16'h1234, 6'd59, 5'd23, 5'd31, 3'd6, 4'd12, 7'd99,
                              1'b1));
      settle();

      // Random part: one register setting per phase, the extremes first.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin zero_ms = 10'd100; one_ms = 10'd200; end
            1: begin zero_ms = 10'd0;   one_ms = 10'd999; end
            2: begin zero_ms = 10'd999; one_ms = 10'd0;   end
            3: begin zero_ms = 10'd1;   one_ms = 10'd2;   end
            4: begin zero_ms = 10'd999; one_ms = 10'd999; end
            default: begin
               zero_ms = 10'($urandom_range(0, 999));
               one_ms = 10'($urandom_range(0, 999));
            end
         endcase
         set_dips(zero_ms, one_ms);

         for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            // A stretch at the start of every block of samples runs without
            // idle cycles on either side.
            steady_flow = (n % 45) < 8;
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               push_sample(noise_sample());
            end else if (roll < 18) begin
               // Broken sequence: the clock jumps, sometimes to a new tag.
               walk_second = 6'($urandom_range(0, 59));
               walk_ms = 10'($urandom_range(0, 999));
               walk_left = $urandom_range(1, 3);
               if ($urandom_range(0, 1) == 1) walk_tag = 16'($urandom());
               push_sample(walk_sample());
            end else begin
               walk_step();
               push_sample(walk_sample());
            end
         end
         steady_flow = 1'b0;
         settle();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
